// ===== src/pwms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase weighted mode sum: shared package
// Widths, default sizes, the queue entry type and the back-end state codes.
// ----------------------------------------------------------------------------
package pwms_pkg;

  localparam int unsigned MODE_COUNT_DEF       = 256;
  localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;

  localparam int unsigned COEF_W    = 24;
  localparam int unsigned MODE_W    = 12;
  localparam int unsigned WNUM_W    = MODE_W + 1;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned TW_W      = 18;
  localparam int unsigned PROD_W    = COEF_W + TW_W;
  localparam int unsigned ACC_W     = 54;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned DROP_BITS = 17;

  localparam int unsigned FIFO_DEPTH = 2;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_re;
    logic signed [COEF_W-1:0] coef_im;
    logic signed [WNUM_W-1:0] wavenum;
    logic                     in_range;
    logic                     last;
  } pwms_item_t;

  typedef struct packed {
    logic       push;
    pwms_item_t item;
  } pwms_push_t;

  typedef struct packed {
    logic full;
    logic valid;
  } pwms_fifo_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PHASE,
    BK_SCALE,
    BK_ROM,
    BK_MUL,
    BK_ACC
  } bk_state_e;

endpackage

// ===== src/pwms_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase weighted mode sum: front end
// Accepts coefficient transactions, maps the storage index to a signed
// wavenumber in FFT order and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module pwms_front #(
  parameter int unsigned MODE_COUNT = pwms_pkg::MODE_COUNT_DEF
) (
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [pwms_pkg::COEF_W-1:0]       coef_re_i,
  input  logic signed [pwms_pkg::COEF_W-1:0]       coef_im_i,
  input  logic        [pwms_pkg::MODE_W-1:0]       mode_index_i,
  input  logic                                     last_mode_i,
  input  pwms_pkg::pwms_fifo_stat_t                fifo_stat_i,
  output pwms_pkg::pwms_push_t                     push_o
);
  import pwms_pkg::*;

  localparam logic [WNUM_W-1:0] ModeCnt = WNUM_W'(MODE_COUNT);
  localparam logic [WNUM_W-1:0] HalfCnt = WNUM_W'(MODE_COUNT / 2);

  logic [WNUM_W-1:0] idx_ext;

  assign idx_ext    = WNUM_W'(mode_index_i);
  assign in_stall_o = fifo_stat_i.full;

  always_comb begin
    push_o.push          = in_valid_i && !fifo_stat_i.full;
    push_o.item.coef_re  = coef_re_i;
    push_o.item.coef_im  = coef_im_i;
    push_o.item.in_range = idx_ext < ModeCnt;
    push_o.item.last     = last_mode_i;
    if (idx_ext < HalfCnt) begin
      push_o.item.wavenum = $signed(idx_ext);
    end else begin
      push_o.item.wavenum = $signed(idx_ext - ModeCnt);
    end
  end

endmodule

// ===== src/pwms_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase weighted mode sum: item queue
// Short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module pwms_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pwms_pkg::pwms_push_t      push_i,
  input  logic                      pop_i,
  output pwms_pkg::pwms_item_t      head_o,
  output pwms_pkg::pwms_fifo_stat_t stat_o
);
  import pwms_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

  pwms_item_t       entry_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;

  assign stat_o.full  = count_q == (PTR_W+1)'(FIFO_DEPTH);
  assign stat_o.valid = count_q != '0;
  assign head_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i.push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i.push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i.push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      entry_q[wr_ptr_q] <= push_i.item;
    end
  end

endmodule

// ===== src/pwms_twiddle_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase weighted mode sum: twiddle table
// Constant cosine and sine table in Q1.17 with a registered read. The
// contents come from a Horner series evaluated while the design elaborates.
// ----------------------------------------------------------------------------
module pwms_twiddle_rom #(
  parameter int unsigned SINE_TABLE_DEPTH = pwms_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rd_en_i,
  input  logic [$clog2(SINE_TABLE_DEPTH)-1:0]          rd_addr_i,
  output logic signed [pwms_pkg::TW_W-1:0]             rd_cos_o,
  output logic signed [pwms_pkg::TW_W-1:0]             rd_sin_o
);
  import pwms_pkg::*;

  localparam logic [63:0] HalfPiQ62    = 64'h6487ED5110B4611A;
  localparam logic [63:0] Q62One       = 64'h4000000000000000;
  localparam logic [63:0] RoundQ45     = 64'h0000100000000000;
  localparam logic [63:0] TwMax        = 64'd131071;
  localparam logic [63:0] TableDepth64 = 64'(SINE_TABLE_DEPTH);
  localparam logic [31:0] TableDepth32 = 32'(SINE_TABLE_DEPTH);

  typedef logic [SINE_TABLE_DEPTH-1:0][2*TW_W-1:0] tw_table_t;

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [TW_W-1:0] quarter_sine(input logic [31:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] sub;
    logic [63:0] s;
    logic [63:0] q;
    x = (HalfPiQ62 / TableDepth64) * 64'(r)
      + ((HalfPiQ62 % TableDepth64) * 64'(r)) / TableDepth64;
    x2 = mul_q62(x, x);
    t  = Q62One;
    for (int n = 13; n >= 1; n--) begin
      p = mul_q62(x2, t);
      case (n)
        13:      sub = p / 64'd702;
        12:      sub = p / 64'd600;
        11:      sub = p / 64'd506;
        10:      sub = p / 64'd420;
        9:       sub = p / 64'd342;
        8:       sub = p / 64'd272;
        7:       sub = p / 64'd210;
        6:       sub = p / 64'd156;
        5:       sub = p / 64'd110;
        4:       sub = p / 64'd72;
        3:       sub = p / 64'd42;
        2:       sub = p / 64'd20;
        default: sub = p / 64'd6;
      endcase
      t = (sub >= Q62One) ? 64'd0 : Q62One - sub;
    end
    s = mul_q62(x, t);
    q = (s + RoundQ45) >> 45;
    if (q > TwMax) begin
      q = TwMax;
    end
    return q[TW_W-1:0];
  endfunction

  function automatic tw_table_t build_table();
    tw_table_t              tab;
    logic [31:0]            k4;
    logic [31:0]            quad;
    logic [31:0]            r;
    logic signed [TW_W-1:0] a;
    logic signed [TW_W-1:0] b;
    logic signed [TW_W-1:0] sn;
    logic signed [TW_W-1:0] cs;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      k4   = 32'(4 * k);
      quad = k4 / TableDepth32;
      r    = k4 % TableDepth32;
      a    = $signed(quarter_sine(r));
      b    = $signed(quarter_sine(TableDepth32 - r));
      case (quad[1:0])
        2'd0: begin
          sn = a;
          cs = b;
        end
        2'd1: begin
          sn = b;
          cs = -a;
        end
        2'd2: begin
          sn = -a;
          cs = -b;
        end
        default: begin
          sn = -b;
          cs = a;
        end
      endcase
      tab[k] = {sn, cs};
    end
    return tab;
  endfunction

  localparam tw_table_t TwTable = build_table();

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_sin_o <= $signed(TwTable[rd_addr_i][2*TW_W-1:TW_W]);
      rd_cos_o <= $signed(TwTable[rd_addr_i][TW_W-1:0]);
    end
  end

endmodule

// ===== src/pwms_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase weighted mode sum: back end
// Sequencer that forms the phase and table index of one queued item, reads
// the twiddle, multiplies, accumulates and delivers the rounded sum.
// ----------------------------------------------------------------------------
module pwms_back #(
  parameter int unsigned SINE_TABLE_DEPTH = pwms_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [pwms_pkg::POS_W-1:0]             pos_frac_i,
  input  pwms_pkg::pwms_fifo_stat_t              fifo_stat_i,
  input  pwms_pkg::pwms_item_t                   head_i,
  output logic                                   pop_o,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [pwms_pkg::SUM_W-1:0]      sum_re_o,
  output logic signed [pwms_pkg::SUM_W-1:0]      sum_im_o,
  output logic                                   saturated_o
);
  import pwms_pkg::*;

  localparam int unsigned IDX_W   = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned SCALE_W = POS_W + IDX_W + 1;
  localparam logic [SCALE_W-1:0] ScaleRound = SCALE_W'(1) << (POS_W - 1);
  localparam logic [IDX_W:0]     DepthIdx   = (IDX_W+1)'(SINE_TABLE_DEPTH);
  localparam logic [ACC_W:0]     AccRound   = (ACC_W+1)'(1) << (DROP_BITS - 1);
  localparam logic signed [SUM_W:0] OutMax  = {2'b00, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W:0] OutMin  = {2'b11, {(SUM_W-1){1'b0}}};

  bk_state_e state_q, state_d;

  logic ld_item, ld_phase, ld_ti, rom_en, ld_prod, acc_upd, out_load, out_free;

  pwms_item_t              item_q;
  logic [POS_W-1:0]        phase_q, phase_d;
  logic [IDX_W-1:0]        ti_q, ti_d;
  logic [SCALE_W-1:0]      scaled;
  logic [IDX_W:0]          ti_full;
  logic signed [TW_W-1:0]  rom_cos, rom_sin;
  logic signed [PROD_W-1:0] p_rc_q, p_is_q, p_rs_q, p_ic_q;
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
  logic signed [ACC_W-1:0] term_re, term_im, acc_re_nx, acc_im_nx;
  logic [ACC_W:0]          rnd_re, rnd_im;
  logic signed [SUM_W:0]   q_re, q_im;
  logic                    hi_re, lo_re, hi_im, lo_im;
  logic signed [SUM_W-1:0] sum_re_d, sum_im_d;
  logic                    out_valid_q;
  logic signed [SUM_W-1:0] sum_re_q, sum_im_q;
  logic                    sat_q;

  pwms_twiddle_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i     (clk_i),
    .rd_en_i   (rom_en),
    .rd_addr_i (ti_q),
    .rd_cos_o  (rom_cos),
    .rd_sin_o  (rom_sin)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    ld_item  = 1'b0;
    ld_phase = 1'b0;
    ld_ti    = 1'b0;
    rom_en   = 1'b0;
    ld_prod  = 1'b0;
    acc_upd  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (fifo_stat_i.valid) begin
          pop_o   = 1'b1;
          ld_item = 1'b1;
          state_d = BK_PHASE;
        end
      end
      BK_PHASE: begin
        ld_phase = 1'b1;
        state_d  = BK_SCALE;
      end
      BK_SCALE: begin
        ld_ti   = 1'b1;
        state_d = BK_ROM;
      end
      BK_ROM: begin
        rom_en  = 1'b1;
        state_d = BK_MUL;
      end
      BK_MUL: begin
        ld_prod = 1'b1;
        state_d = BK_ACC;
      end
      BK_ACC: begin
        if (!item_q.last) begin
          acc_upd = 1'b1;
          state_d = BK_IDLE;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Phase is the wavenumber times the position, modulo one turn.
  assign phase_d = {{(POS_W-WNUM_W){item_q.wavenum[WNUM_W-1]}}, item_q.wavenum} * pos_frac_i;

  assign scaled  = SCALE_W'(phase_q) * SCALE_W'(SINE_TABLE_DEPTH) + ScaleRound;
  assign ti_full = scaled[SCALE_W-1:POS_W];
  assign ti_d    = (ti_full >= DepthIdx) ? '0 : ti_full[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ld_item) begin
      item_q <= head_i;
    end
    if (ld_phase) begin
      phase_q <= phase_d;
    end
    if (ld_ti) begin
      ti_q <= ti_d;
    end
    if (ld_prod) begin
      p_rc_q <= item_q.coef_re * rom_cos;
      p_is_q <= item_q.coef_im * rom_sin;
      p_rs_q <= item_q.coef_re * rom_sin;
      p_ic_q <= item_q.coef_im * rom_cos;
    end
  end

  always_comb begin
    term_re   = ACC_W'(p_rc_q) - ACC_W'(p_is_q);
    term_im   = ACC_W'(p_rs_q) + ACC_W'(p_ic_q);
    acc_re_nx = item_q.in_range ? acc_re_q + term_re : acc_re_q;
    acc_im_nx = item_q.in_range ? acc_im_q + term_im : acc_im_q;
    rnd_re    = (ACC_W+1)'(acc_re_nx) + AccRound;
    rnd_im    = (ACC_W+1)'(acc_im_nx) + AccRound;
    q_re      = (SUM_W+1)'($signed(rnd_re[ACC_W:DROP_BITS]));
    q_im      = (SUM_W+1)'($signed(rnd_im[ACC_W:DROP_BITS]));
    hi_re     = q_re > OutMax;
    lo_re     = q_re < OutMin;
    hi_im     = q_im > OutMax;
    lo_im     = q_im < OutMin;
    sum_re_d  = hi_re ? OutMax[SUM_W-1:0] : (lo_re ? OutMin[SUM_W-1:0] : q_re[SUM_W-1:0]);
    sum_im_d  = hi_im ? OutMax[SUM_W-1:0] : (lo_im ? OutMin[SUM_W-1:0] : q_im[SUM_W-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q    <= '0;
      acc_im_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        acc_re_q <= '0;
        acc_im_q <= '0;
      end else if (acc_upd) begin
        acc_re_q <= acc_re_nx;
        acc_im_q <= acc_im_nx;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sum_re_q <= sum_re_d;
      sum_im_q <= sum_im_d;
      sat_q    <= hi_re || lo_re || hi_im || lo_im;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sum_re_o    = sum_re_q;
  assign sum_im_o    = sum_im_q;
  assign saturated_o = sat_q;

endmodule

// ===== src/phase_weighted_mode_sum_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase weighted mode sum: top level
// Evaluates an inverse Fourier sum at one configured fractional position,
// one complex coefficient per transaction, and delivers the saturated sum on
// the transaction that carries the last mode.
//
//   Channel  Direction  Handshake                 Payload
//   in       sink       in_valid_i / in_stall_o   coef_re, coef_im, mode_index,
//                                                 last_mode
//   out      source     out_valid_o / out_stall_i sum_re, sum_im, saturated
//   cfg      sink       cfg_we_i                  cfg_wdata_i (position fraction)
//
// The back-end sequencer takes each item through queue pop, phase multiply,
// index scaling, table read, complex multiply and accumulate, in that order.
// A two-entry queue lets the front take further transactions meanwhile.
// A result held by out_stall_i holds the back end on the last item of a sum.
// Reset clears the queue, the accumulators and the position register; the
// twiddle table is constant and needs no clearing pass.
// ----------------------------------------------------------------------------
module phase_weighted_mode_sum_top #(
  parameter int unsigned MODE_COUNT       = pwms_pkg::MODE_COUNT_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = pwms_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic        [pwms_pkg::POS_W-1:0]   cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [pwms_pkg::COEF_W-1:0]  coef_re_i,
  input  logic signed [pwms_pkg::COEF_W-1:0]  coef_im_i,
  input  logic        [pwms_pkg::MODE_W-1:0]  mode_index_i,
  input  logic                                last_mode_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pwms_pkg::SUM_W-1:0]   sum_re_o,
  output logic signed [pwms_pkg::SUM_W-1:0]   sum_im_o,
  output logic                                saturated_o
);
  import pwms_pkg::*;

  logic [POS_W-1:0] pos_frac_q;
  pwms_push_t       push;
  pwms_fifo_stat_t  fifo_stat;
  pwms_item_t       head;
  logic             pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_frac_q <= '0;
    end else if (cfg_we_i) begin
      pos_frac_q <= cfg_wdata_i;
    end
  end

  pwms_front #(
    .MODE_COUNT(MODE_COUNT)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .coef_re_i    (coef_re_i),
    .coef_im_i    (coef_im_i),
    .mode_index_i (mode_index_i),
    .last_mode_i  (last_mode_i),
    .fifo_stat_i  (fifo_stat),
    .push_o       (push)
  );

  pwms_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (fifo_stat)
  );

  pwms_back #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pos_frac_i  (pos_frac_q),
    .fifo_stat_i (fifo_stat),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sum_re_o    (sum_re_o),
    .sum_im_o    (sum_im_o),
    .saturated_o (saturated_o)
  );

  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> fifo_stat.valid)
    else $error("back end popped an empty queue");

  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push && !pop |=> fifo_stat.valid)
    else $error("queued transaction not visible to the back end");

  a_no_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !saturated_o)
    else $error("accumulator sum was clipped");

endmodule

// ===== tb/phase_weighted_mode_sum_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase weighted mode sum: testbench
// Streams complex coefficients into the block and predicts every emitted sum
// with an independent bit-accurate model of the twiddle table, the phase ramp
// and the wrapping accumulators. A directed opening covers the coefficient
// and index extremes, out-of-range modes, empty sums and the table index
// wrap. Random sums of mixed length follow under several position settings.
// Both handshakes idle and stall at random, with stretches at full rate.
// ----------------------------------------------------------------------------
module phase_weighted_mode_sum_top_tb;
  import pwms_pkg::*;

  localparam int unsigned MODE_N = MODE_COUNT_DEF;
  localparam int unsigned TAB_N = SINE_TABLE_DEPTH_DEF;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
  localparam int TW_PEAK = 131071;
  localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_MIN = -(longint'(1) <<< (SUM_W - 1));
  localparam logic signed [COEF_W-1:0] COEF_MAX = 24'sh7F_FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 24'sh80_0000;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_MODES_PER_SETTING = 172;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic signed [COEF_W-1:0] re;
    logic signed [COEF_W-1:0] im;
    logic [MODE_W-1:0]        index;
    logic                     last;
  } mode_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] re;
    logic signed [SUM_W-1:0] im;
    logic                    clipped;
  } mode_sum_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [POS_W-1:0]         cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [COEF_W-1:0] coef_re_i = '0;
  logic signed [COEF_W-1:0] coef_im_i = '0;
  logic [MODE_W-1:0]        mode_index_i = '0;
  logic                     last_mode_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [SUM_W-1:0]  sum_re_o;
  logic signed [SUM_W-1:0]  sum_im_o;
  logic                     saturated_o;

  int cos_tab [TAB_N];
  int sin_tab [TAB_N];
  logic [POS_W-1:0] position_q = '0;
  logic [ACC_W-1:0] acc_re_q = '0;
  logic [ACC_W-1:0] acc_im_q = '0;

  mode_item_t pending_modes [$];
  mode_sum_t  expected_sums [$];
  mode_item_t next_mode;
  mode_sum_t  want_sum;

  int  mismatch_count = 0;
  int  modes_accepted = 0;
  int  sums_checked = 0;
  int  settings_used = 0;
  int  cycle_count = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  stall_next;
  bit  in_burst = 1'b0;
  bit  out_burst = 1'b0;

  phase_weighted_mode_sum_top #(
    .MODE_COUNT       (MODE_N),
    .SINE_TABLE_DEPTH (TAB_N)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .coef_re_i   (coef_re_i),
    .coef_im_i   (coef_im_i),
    .mode_index_i(mode_index_i),
    .last_mode_i (last_mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sum_re_o    (sum_re_o),
    .sum_im_o    (sum_im_o),
    .saturated_o (saturated_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[125:62];
  endfunction

  function automatic int quarter_sine(input int unsigned r);
    logic [63:0] x, x2, t, s, q, sub;
    x = (HALF_PI_Q62 / 64'(TAB_N)) * 64'(r)
        + ((HALF_PI_Q62 % 64'(TAB_N)) * 64'(r)) / 64'(TAB_N);
    x2 = mul_q62(x, x);
    t = Q62_ONE;
    for (int n = 13; n >= 1; n--) begin
      sub = mul_q62(x2, t) / 64'(4 * n * n + 2 * n);
      t = (sub >= Q62_ONE) ? 64'd0 : Q62_ONE - sub;
    end
    s = mul_q62(x, t);
    q = (s + (64'd1 << 44)) >> 45;
    if (q > 64'(TW_PEAK)) q = 64'(TW_PEAK);
    return int'(q);
  endfunction

  function automatic void build_twiddles();
    int unsigned quad, r;
    int a, b;
    for (int unsigned k = 0; k < TAB_N; k++) begin
      quad = (4 * k) / TAB_N;
      r = (4 * k) % TAB_N;
      a = quarter_sine(r);
      b = quarter_sine(TAB_N - r);
      case (quad)
        0: begin
          sin_tab[k] = a;
          cos_tab[k] = b;
        end
        1: begin
          sin_tab[k] = b;
          cos_tab[k] = -a;
        end
        2: begin
          sin_tab[k] = -a;
          cos_tab[k] = -b;
        end
        default: begin
          sin_tab[k] = -b;
          cos_tab[k] = a;
        end
      endcase
    end
  endfunction

  function automatic logic signed [SUM_W-1:0] round_and_clip(input logic [ACC_W-1:0] acc,
                                                              inout bit clip);
    logic signed [ACC_W-1:0] acc_s;
    longint v;
    acc_s = acc;
    v = acc_s;
    v = (v + (longint'(1) <<< (DROP_BITS - 1))) >>> DROP_BITS;
    if (v > SUM_MAX) begin
      clip = 1'b1;
      v = SUM_MAX;
    end else if (v < SUM_MIN) begin
      clip = 1'b1;
      v = SUM_MIN;
    end
    return SUM_W'(v);
  endfunction

  function automatic void accumulate_mode(input mode_item_t it);
    logic [31:0] wnum, phase;
    logic [63:0] tidx;
    longint c, s, re, im, pr, pim;
    mode_sum_t res;
    bit clip;
    re = it.re;
    im = it.im;
    if (it.index < MODE_N) begin
      wnum = (it.index < MODE_N / 2) ? 32'(it.index) : 32'(it.index) - 32'(MODE_N);
      phase = wnum * position_q;
      tidx = ({32'd0, phase} * 64'(TAB_N) + 64'h8000_0000) >> 32;
      if (tidx >= 64'(TAB_N)) tidx = '0;
      c = cos_tab[tidx];
      s = sin_tab[tidx];
      pr = re * c - im * s;
      pim = re * s + im * c;
      acc_re_q = acc_re_q + ACC_W'(pr);
      acc_im_q = acc_im_q + ACC_W'(pim);
    end
    if (it.last) begin
      clip = 1'b0;
      res.re = round_and_clip(acc_re_q, clip);
      res.im = round_and_clip(acc_im_q, clip);
      res.clipped = clip;
      expected_sums.push_back(res);
      acc_re_q = '0;
      acc_im_q = '0;
    end
  endfunction

  function automatic logic signed [COEF_W-1:0] random_coef();
    case ($urandom_range(0, 9))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return $urandom_range(0, 1) ? '0 : '1;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] random_index();
    if ($urandom_range(0, 19) < 17) return MODE_W'($urandom_range(0, MODE_N - 1));
    return MODE_W'($urandom_range(MODE_N, (1 << MODE_W) - 1));
  endfunction

  function automatic void push_mode(input logic signed [COEF_W-1:0] re,
                                    input logic signed [COEF_W-1:0] im,
                                    input logic [MODE_W-1:0] index, input logic last);
    pending_modes.push_back(mode_item_t'{re, im, index, last});
  endfunction

  function automatic void queue_random_modes(input int count);
    int left, len, pick;
    bit noisy;
    left = count;
    while (left > 0) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) len = $urandom_range(1, 8);
      else if (pick < 18) len = $urandom_range(9, 64);
      else len = $urandom_range(MODE_N - 20, MODE_N + 40);
      noisy = ($urandom_range(0, 9) == 0);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        push_mode(random_coef(), random_coef(), random_index(),
                  noisy ? 1'($urandom_range(0, 1)) : (i == len - 1));
      end
      left -= len;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("MISMATCH at cycle %0d: %0s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic drain_and_settle();
    do @(negedge clk_i);
    while (pending_modes.size() != 0 || in_valid_i || expected_sums.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_position(input logic [POS_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    position_q = value;
    settings_used++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        accumulate_mode(mode_item_t'{coef_re_i, coef_im_i, mode_index_i, last_mode_i});
        modes_accepted++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_modes.size() != 0) begin
          next_mode = pending_modes.pop_front();
          coef_re_i <= next_mode.re;
          coef_im_i <= next_mode.im;
          mode_index_i <= next_mode.index;
          last_mode_i <= next_mode.last;
          in_valid_i <= 1'b1;
          gap_left <= in_burst ? 0 : $urandom_range(0, 11);
          if ($urandom_range(0, 31) == 0) in_burst <= !in_burst;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      stall_next = stall_left;
      if (out_valid_o && !out_stall_i) begin
        if (expected_sums.size() == 0) begin
          report_mismatch($sformatf("unexpected sum re=%0d im=%0d", sum_re_o, sum_im_o));
        end else begin
          want_sum = expected_sums.pop_front();
          if (sum_re_o !== want_sum.re)
            report_mismatch($sformatf("sum %0d real part %0d, expected %0d",
                                      sums_checked, sum_re_o, want_sum.re));
          if (sum_im_o !== want_sum.im)
            report_mismatch($sformatf("sum %0d imaginary part %0d, expected %0d",
                                      sums_checked, sum_im_o, want_sum.im));
          if (saturated_o !== want_sum.clipped)
            report_mismatch($sformatf("sum %0d saturation flag %b, expected %b",
                                      sums_checked, saturated_o, want_sum.clipped));
          sums_checked++;
        end
        stall_next = out_burst ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 31) == 0) out_burst <= !out_burst;
      end else if (stall_left != 0) begin
        stall_next = stall_left - 1;
      end
      stall_left <= stall_next;
      out_stall_i <= (stall_next != 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    build_twiddles();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The position is still at its reset value of zero here.
    push_mode(COEF_MAX, COEF_MIN, 12'd0, 1'b1);
    push_mode(COEF_MIN, COEF_MAX, 12'd255, 1'b0);
    push_mode('1, '0, 12'd128, 1'b0);
    push_mode('0, '1, 12'd127, 1'b1);
    push_mode(COEF_MAX, COEF_MAX, 12'd256, 1'b1);
    push_mode(COEF_MIN, COEF_MIN, 12'd4095, 1'b0);
    push_mode(24'sd12345, -24'sd54321, 12'd5, 1'b1);
    drain_and_settle();

    // A phase just short of a full turn rounds past the end of the table and wraps to entry zero.
    write_position(32'hFFFF_FFFF);
    push_mode(COEF_MAX, COEF_MAX, 12'd1, 1'b0);
    push_mode(COEF_MIN, COEF_MAX, 12'd255, 1'b0);
    push_mode(COEF_MAX, COEF_MIN, 12'd128, 1'b0);
    push_mode(COEF_MIN, COEF_MIN, 12'd2048, 1'b1);
    drain_and_settle();

    write_position(32'h8000_0000);
    push_mode(COEF_MAX, COEF_MAX, 12'd1, 1'b0);
    push_mode(COEF_MIN, COEF_MAX, 12'd3, 1'b1);
    push_mode(COEF_MIN, COEF_MIN, 12'd2, 1'b1);
    drain_and_settle();

    write_position(32'h1234_5678);
    push_mode(COEF_MAX, COEF_MIN, 12'd127, 1'b0);
    push_mode(COEF_MIN, COEF_MAX, 12'd128, 1'b0);
    push_mode(COEF_MAX, COEF_MAX, 12'd129, 1'b0);
    push_mode(-24'sd1, COEF_MIN, 12'd64, 1'b0);
    push_mode(24'sd4660, -24'sd22136, 12'd200, 1'b1);
    push_mode(COEF_MAX, COEF_MAX, 12'd3000, 1'b1);
    push_mode(COEF_MIN, COEF_MIN, 12'd256, 1'b1);

    for (int p = 0; p < 6; p++) begin
      drain_and_settle();
      case (p)
        0: write_position(32'h0000_0001);
        1: write_position(32'h0040_0000);
        2: write_position($urandom);
        3: write_position(32'hFFFF_FFFF);
        4: write_position(32'h8000_0000);
        default: write_position($urandom);
      endcase
      queue_random_modes(RANDOM_MODES_PER_SETTING);
    end

    // The last random sum may be left open, so one more mode closes it.
    push_mode(random_coef(), random_coef(), random_index(), 1'b1);
    drain_and_settle();

    $display("Checked %0d sums from %0d coefficient transactions across %0d position writes,",
             sums_checked, modes_accepted, settings_used);
    $display("with directed extremes followed by random sums of mixed length.");
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/pwms_pkg.sv
src/pwms_front.sv
src/pwms_fifo.sv
src/pwms_twiddle_rom.sv
src/pwms_back.sv
src/phase_weighted_mode_sum_top.sv
tb/phase_weighted_mode_sum_top_tb.sv
